// File: hw/rtl/epoch_seconds_to_calendar_core_defines.svh
// assertion macros for the epoch seconds to calendar core
`ifndef EPOCH_SECONDS_TO_CALENDAR_CORE_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_CORE_DEFINES_SVH

// same-cycle implication
`define ESC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("epoch_seconds_to_calendar_core: same-cycle check failed");

// next-cycle implication
`define ESC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("epoch_seconds_to_calendar_core: next-cycle check failed");

`endif

// File: hw/rtl/esc_pkg.sv
// shared types, constants and the month table of the epoch seconds to calendar core
package esc_pkg;

  localparam int unsigned InWidth       = 34;
  localparam int unsigned SecondsWidth  = 34;
  localparam int unsigned EffWidth      = (SecondsWidth < InWidth) ? SecondsWidth : InWidth;

  localparam int unsigned YearWidth     = 12;
  localparam int unsigned MonthWidth    = 4;
  localparam int unsigned DayWidth      = 5;
  localparam int unsigned HourWidth     = 5;
  localparam int unsigned MinuteWidth   = 6;
  localparam int unsigned SecondWidth   = 6;

  localparam longint unsigned SecsPerDay    = 86400;
  localparam longint unsigned SecsPerHour   = 3600;
  localparam longint unsigned SecsPerMinute = 60;

  localparam int unsigned DaysWidth =
    $clog2((((64'd1 << EffWidth) - 64'd1) / SecsPerDay) + 64'd1);
  localparam int unsigned RemWidth    = $clog2(SecsPerDay);
  localparam int unsigned HourRemWidth = $clog2(SecsPerHour);

  localparam logic [InWidth-1:0] InMask = (SecondsWidth >= InWidth) ? {InWidth{1'b1}} :
    ({InWidth{1'b1}} >> (InWidth - SecondsWidth));

  // 86400 = 675 << 7, 3600 = 225 << 4, 60 = 15 << 2; odd parts by rounded-up reciprocal
  localparam int unsigned DayShift       = 7;
  localparam int unsigned DayOdd         = 675;
  localparam int unsigned DayOddWidth    = 10;
  localparam int unsigned DayInWidth     = EffWidth - DayShift;
  localparam int unsigned DayRecipShift  = DayInWidth + DayOddWidth;
  localparam int unsigned DayRecipWidth  = DayInWidth + 1;
  localparam int unsigned DayProdWidth   = DayInWidth + DayRecipWidth;
  localparam logic [DayRecipWidth-1:0] DayRecip =
    DayRecipWidth'(((64'd1 << DayRecipShift) + 64'(DayOdd) - 64'd1) / 64'(DayOdd));

  localparam int unsigned HourShift      = 4;
  localparam int unsigned HourOdd        = 225;
  localparam int unsigned HourOddWidth   = 8;
  localparam int unsigned HourInWidth    = RemWidth - HourShift;
  localparam int unsigned HourRecipShift = HourInWidth + HourOddWidth;
  localparam int unsigned HourRecipWidth = HourInWidth + 1;
  localparam int unsigned HourProdWidth  = HourInWidth + HourRecipWidth;
  localparam logic [HourRecipWidth-1:0] HourRecip =
    HourRecipWidth'(((64'd1 << HourRecipShift) + 64'(HourOdd) - 64'd1) / 64'(HourOdd));

  localparam int unsigned MinShift       = 2;
  localparam int unsigned MinOdd         = 15;
  localparam int unsigned MinOddWidth    = 4;
  localparam int unsigned MinInWidth     = HourRemWidth - MinShift;
  localparam int unsigned MinRecipShift  = MinInWidth + MinOddWidth;
  localparam int unsigned MinRecipWidth  = MinInWidth + 1;
  localparam int unsigned MinProdWidth   = MinInWidth + MinRecipWidth;
  localparam logic [MinRecipWidth-1:0] MinRecip =
    MinRecipWidth'(((64'd1 << MinRecipShift) + 64'(MinOdd) - 64'd1) / 64'(MinOdd));

  localparam int unsigned EpochYear   = 1970;
  localparam int unsigned DaysNormal  = 365;
  localparam int unsigned Mod4Width   = 2;
  localparam int unsigned Mod100Width = 7;
  localparam int unsigned Mod400Width = 9;
  localparam int unsigned YearLenWidth = 9;
  localparam int unsigned MonthLenWidth = 5;

  localparam logic [MonthWidth-1:0] MonthJan = 4'd0;
  localparam logic [MonthWidth-1:0] MonthFeb = 4'd1;
  localparam logic [MonthWidth-1:0] MonthDec = 4'd11;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PtrWidth   = $clog2(QueueDepth);

  typedef struct packed {
    logic [DaysWidth-1:0]   days;
    logic [HourWidth-1:0]   hour;
    logic [MinuteWidth-1:0] minute;
    logic [SecondWidth-1:0] second;
  } esc_item_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DAY,
    F_SOD,
    F_HOUR,
    F_HREM,
    F_MIN,
    F_SEC,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_YEAR,
    B_MONTH,
    B_DONE
  } back_state_e;

  function automatic logic [MonthLenWidth-1:0] month_len(input logic [MonthWidth-1:0] idx,
                                                         input logic leap);
    logic [MonthLenWidth-1:0] len;
    case (idx)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: hw/rtl/esc_front.sv
// front end: takes the seconds count and splits it into days, hour, minute, second
module esc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [esc_pkg::InWidth-1:0] epoch_seconds_i,
  output logic                        full_o,
  output logic                        item_valid_o,
  input  logic                        item_ready_i,
  output esc_pkg::esc_item_t          item_o
);
  import esc_pkg::*;

  front_state_e              state_q, state_d;
  logic [InWidth-1:0]        a_q, a_d;
  logic [DaysWidth-1:0]      days_q, days_d;
  logic [RemWidth-1:0]       sod_q, sod_d;
  logic [HourWidth-1:0]      hour_q, hour_d;
  logic [HourRemWidth-1:0]   rem_q, rem_d;
  logic [MinuteWidth-1:0]    minute_q, minute_d;
  logic [SecondWidth-1:0]    second_q, second_d;

  logic [DayInWidth-1:0]     day_in;
  logic [DayProdWidth-1:0]   day_prod;
  logic [DayInWidth-1:0]     day_back;
  logic [DayInWidth-1:0]     day_left;
  logic [HourInWidth-1:0]    hour_in;
  logic [HourProdWidth-1:0]  hour_prod;
  logic [HourInWidth-1:0]    hour_back;
  logic [HourInWidth-1:0]    hour_left;
  logic [MinInWidth-1:0]     min_in;
  logic [MinProdWidth-1:0]   min_prod;
  logic [MinInWidth-1:0]     min_back;
  logic [MinInWidth-1:0]     min_left;

  // low bits of each divisor are a shift, the odd part a reciprocal multiply
  assign day_in    = a_q[EffWidth-1:DayShift];
  assign day_prod  = DayProdWidth'(day_in) * DayProdWidth'(DayRecip);
  assign day_back  = DayInWidth'(days_q) * DayInWidth'(DayOdd);
  assign day_left  = day_in - day_back;
  assign hour_in   = sod_q[RemWidth-1:HourShift];
  assign hour_prod = HourProdWidth'(hour_in) * HourProdWidth'(HourRecip);
  assign hour_back = HourInWidth'(hour_q) * HourInWidth'(HourOdd);
  assign hour_left = hour_in - hour_back;
  assign min_in    = rem_q[HourRemWidth-1:MinShift];
  assign min_prod  = MinProdWidth'(min_in) * MinProdWidth'(MinRecip);
  assign min_back  = MinInWidth'(minute_q) * MinInWidth'(MinOdd);
  assign min_left  = min_in - min_back;

  always_comb begin
    state_d      = state_q;
    a_d          = a_q;
    days_d       = days_q;
    sod_d        = sod_q;
    hour_d       = hour_q;
    rem_d        = rem_q;
    minute_d     = minute_q;
    second_d     = second_q;
    item_valid_o = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (push_i) begin
          a_d     = epoch_seconds_i & InMask;
          state_d = F_DAY;
        end
      end
      F_DAY: begin
        days_d  = day_prod[DayRecipShift +: DaysWidth];
        state_d = F_SOD;
      end
      F_SOD: begin
        sod_d   = {day_left[DayOddWidth-1:0], a_q[DayShift-1:0]};
        state_d = F_HOUR;
      end
      F_HOUR: begin
        hour_d  = hour_prod[HourRecipShift +: HourWidth];
        state_d = F_HREM;
      end
      F_HREM: begin
        rem_d   = {hour_left[HourOddWidth-1:0], sod_q[HourShift-1:0]};
        state_d = F_MIN;
      end
      F_MIN: begin
        minute_d = min_prod[MinRecipShift +: MinuteWidth];
        state_d  = F_SEC;
      end
      F_SEC: begin
        second_d = {min_left[MinOddWidth-1:0], rem_q[MinShift-1:0]};
        state_d  = F_PUSH;
      end
      F_PUSH: begin
        item_valid_o = 1'b1;
        if (item_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    days_q   <= days_d;
    sod_q    <= sod_d;
    hour_q   <= hour_d;
    rem_q    <= rem_d;
    minute_q <= minute_d;
    second_q <= second_d;
  end

  assign full_o        = (state_q != F_IDLE);
  assign item_o.days   = days_q;
  assign item_o.hour   = hour_q;
  assign item_o.minute = minute_q;
  assign item_o.second = second_q;

endmodule

// File: hw/rtl/esc_fifo.sv
// short queue between the front end and the calendar walker
module esc_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  esc_pkg::esc_item_t item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output esc_pkg::esc_item_t item_o
);
  import esc_pkg::*;

  esc_item_t           mem_q [QueueDepth];
  logic [PtrWidth-1:0] wr_q, wr_d;
  logic [PtrWidth-1:0] rd_q, rd_d;
  logic [PtrWidth:0]   cnt_q, cnt_d;
  logic                do_push;
  logic                do_pop;

  assign push_ready_o = (cnt_q != (PtrWidth + 1)'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign item_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrWidth'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrWidth'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// File: hw/rtl/esc_back.sv
// back end: walks years and months from 1970 and holds the result register
module esc_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            item_valid_i,
  output logic                            item_ready_o,
  input  esc_pkg::esc_item_t              item_i,
  output logic                            empty_o,
  input  logic                            pop_i,
  output logic [esc_pkg::YearWidth-1:0]   cal_year_o,
  output logic [esc_pkg::MonthWidth-1:0]  cal_month_o,
  output logic [esc_pkg::DayWidth-1:0]    cal_day_o,
  output logic [esc_pkg::HourWidth-1:0]   cal_hour_o,
  output logic [esc_pkg::MinuteWidth-1:0] cal_minute_o,
  output logic [esc_pkg::SecondWidth-1:0] cal_second_o
);
  import esc_pkg::*;

  back_state_e              state_q, state_d;
  logic [DaysWidth-1:0]     days_q, days_d;
  logic [YearWidth-1:0]     year_q, year_d;
  logic [Mod4Width-1:0]     m4_q, m4_d;
  logic [Mod100Width-1:0]   m100_q, m100_d;
  logic [Mod400Width-1:0]   m400_q, m400_d;
  logic [MonthWidth-1:0]    mon_q, mon_d;
  logic [HourWidth-1:0]     hour_q, hour_d;
  logic [MinuteWidth-1:0]   minute_q, minute_d;
  logic [SecondWidth-1:0]   second_q, second_d;
  logic                     out_valid_q, out_valid_d;

  logic                     leap;
  logic [YearLenWidth-1:0]  ylen;
  logic [MonthLenWidth-1:0] mlen;
  logic [DaysWidth-1:0]     ylen_ext;
  logic [DaysWidth-1:0]     mlen_ext;
  logic                     load_out;

  assign leap     = (m400_q == '0) || ((m4_q == '0) && (m100_q != '0));
  assign ylen     = YearLenWidth'(DaysNormal) + {{(YearLenWidth - 1){1'b0}}, leap};
  assign mlen     = month_len(mon_q, leap);
  assign ylen_ext = DaysWidth'(ylen);
  assign mlen_ext = DaysWidth'(mlen);

  always_comb begin
    state_d      = state_q;
    days_d       = days_q;
    year_d       = year_q;
    m4_d         = m4_q;
    m100_d       = m100_q;
    m400_d       = m400_q;
    mon_d        = mon_q;
    hour_d       = hour_q;
    minute_d     = minute_q;
    second_d     = second_q;
    item_ready_o = 1'b0;
    load_out     = 1'b0;
    case (state_q)
      B_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          days_d   = item_i.days;
          hour_d   = item_i.hour;
          minute_d = item_i.minute;
          second_d = item_i.second;
          year_d   = YearWidth'(EpochYear);
          m4_d     = Mod4Width'(EpochYear % 4);
          m100_d   = Mod100Width'(EpochYear % 100);
          m400_d   = Mod400Width'(EpochYear % 400);
          state_d  = B_YEAR;
        end
      end
      B_YEAR: begin
        if (days_q < ylen_ext) begin
          mon_d   = MonthJan;
          state_d = B_MONTH;
        end else begin
          days_d = days_q - ylen_ext;
          year_d = year_q + 1'b1;
          m4_d   = m4_q + 1'b1;
          m100_d = (m100_q == Mod100Width'(99)) ? '0 : m100_q + 1'b1;
          m400_d = (m400_q == Mod400Width'(399)) ? '0 : m400_q + 1'b1;
        end
      end
      B_MONTH: begin
        if ((mon_q == MonthDec) || (days_q < mlen_ext)) begin
          state_d = B_DONE;
        end else begin
          days_d = days_q - mlen_ext;
          mon_d  = mon_q + 1'b1;
        end
      end
      B_DONE: begin
        if (!out_valid_q || pop_i) begin
          load_out = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    days_q   <= days_d;
    year_q   <= year_d;
    m4_q     <= m4_d;
    m100_q   <= m100_d;
    m400_q   <= m400_d;
    mon_q    <= mon_d;
    hour_q   <= hour_d;
    minute_q <= minute_d;
    second_q <= second_d;
    if (load_out) begin
      cal_year_o   <= year_q;
      cal_month_o  <= mon_q + 1'b1;
      cal_day_o    <= days_q[DayWidth-1:0] + 1'b1;
      cal_hour_o   <= hour_q;
      cal_minute_o <= minute_q;
      cal_second_o <= second_q;
    end
  end

  assign empty_o = !out_valid_q;

endmodule

// File: hw/rtl/epoch_seconds_to_calendar_core.sv
// top level of the epoch seconds to calendar core (UTC, Gregorian)
// input queue side: drive epoch_seconds_i with push_i; a transfer happens on a clock
//   edge with push_i high and full_o low. full_o stays high while the front end splits.
// result queue side: while empty_o is low the oldest result sits on the cal_* ports;
//   a transfer happens on a clock edge with pop_i high and empty_o low.
// front end: constant divisions by reciprocal multiply, one step per cycle, then it hands
//   the item to a two-entry queue, waiting while that is full; no new input until then.
// back end: one year per cycle from 1970, then one month per cycle; the slower side sets
//   the sustained rate, which past the first few years is the year walk.
// a stalled receiver holds the result register; the back end parks the next result
//   until the register frees, the queue then fills and full_o pushes back.
// reset clears the front end, queue and walker control and leaves the result queue empty;
//   no clearing pass is needed.
`include "epoch_seconds_to_calendar_core_defines.svh"

module epoch_seconds_to_calendar_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  output logic                            full_o,
  input  logic [esc_pkg::InWidth-1:0]     epoch_seconds_i,
  output logic                            empty_o,
  input  logic                            pop_i,
  output logic [esc_pkg::YearWidth-1:0]   cal_year_o,
  output logic [esc_pkg::MonthWidth-1:0]  cal_month_o,
  output logic [esc_pkg::DayWidth-1:0]    cal_day_o,
  output logic [esc_pkg::HourWidth-1:0]   cal_hour_o,
  output logic [esc_pkg::MinuteWidth-1:0] cal_minute_o,
  output logic [esc_pkg::SecondWidth-1:0] cal_second_o
);
  import esc_pkg::*;

  logic      q_push_valid;
  logic      q_push_ready;
  esc_item_t q_push_item;
  logic      q_pop_valid;
  logic      q_pop_ready;
  esc_item_t q_pop_item;
  logic      result_ok;

  esc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push_i),
    .epoch_seconds_i (epoch_seconds_i),
    .full_o          (full_o),
    .item_valid_o    (q_push_valid),
    .item_ready_i    (q_push_ready),
    .item_o          (q_push_item)
  );

  esc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .item_i       (q_push_item),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .item_o       (q_pop_item)
  );

  esc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_pop_valid),
    .item_ready_o (q_pop_ready),
    .item_i       (q_pop_item),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .cal_year_o   (cal_year_o),
    .cal_month_o  (cal_month_o),
    .cal_day_o    (cal_day_o),
    .cal_hour_o   (cal_hour_o),
    .cal_minute_o (cal_minute_o),
    .cal_second_o (cal_second_o)
  );

  assign result_ok = (cal_month_o >= 4'd1) && (cal_month_o <= 4'd12) && (cal_day_o >= 5'd1) &&
                     (cal_hour_o <= 5'd23) && (cal_minute_o <= 6'd59) &&
                     (cal_second_o <= 6'd59);

  `ESC_ASSERT_NEXT(a_accept_busy, push_i && !full_o, full_o)
  `ESC_ASSERT_NOW(a_result_range, !empty_o, result_ok)
  `ESC_ASSERT_NEXT(a_queue_fill, q_push_valid && q_push_ready, q_pop_valid)

endmodule
